### hdl/iprtl_pkg.sv
// shared types and constants for the ip range table lookup core
// no dependencies; used by iprtl_mem, iprtl_search and the top level
package iprtl_pkg;

	localparam int unsigned IDX_W  = 12;
	localparam int unsigned IP_W   = 32;
	localparam int unsigned PAY_W  = 32;
	localparam int unsigned CNT_W  = 13;
	localparam int unsigned S_DATA_W = 112;
	localparam int unsigned M_DATA_W = 48;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] match_index;
		logic [PAY_W-1:0] match_payload;
	} result_t;

endpackage

### hdl/iprtl_mem.sv
// range start and payload tables, one write port and one registered read port
// depends on iprtl_pkg
module iprtl_mem #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned AW          = 12
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [iprtl_pkg::IP_W-1:0]  wr_start,
	input  logic [iprtl_pkg::PAY_W-1:0] wr_payload,
	input  logic [AW-1:0]               rd_addr,
	output logic [iprtl_pkg::IP_W-1:0]  rd_start,
	output logic [iprtl_pkg::PAY_W-1:0] rd_payload
);

	logic [iprtl_pkg::IP_W-1:0]  start_mem   [TABLE_DEPTH];
	logic [iprtl_pkg::PAY_W-1:0] payload_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_addr]   <= wr_start;
			payload_mem[wr_addr] <= wr_payload;
		end
		rd_start   <= start_mem[rd_addr];
		rd_payload <= payload_mem[rd_addr];
	end

endmodule

### hdl/iprtl_search.sv
// bisection sequencer: one table probe per cycle against the registered read data
// depends on iprtl_pkg; drives the read address of iprtl_mem
module iprtl_search #(
	parameter int unsigned TABLE_DEPTH = 4096,
	parameter int unsigned AW          = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [iprtl_pkg::CNT_W-1:0] entry_count,
	input  logic [iprtl_pkg::IP_W-1:0]  ip_address,
	output logic                        idle,
	output logic [AW-1:0]               rd_addr,
	input  logic [iprtl_pkg::IP_W-1:0]  rd_start,
	input  logic [iprtl_pkg::PAY_W-1:0] rd_payload,
	input  logic                        out_free,
	output logic                        res_load,
	output iprtl_pkg::result_t          res
);

	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	iprtl_pkg::state_t  state_q, state_d;
	logic [CW-1:0]      lo_q, lo_d, len_q, len_d;
	logic [AW-1:0]      probe_q, probe_d;
	logic [iprtl_pkg::IP_W-1:0] ip_q;
	iprtl_pkg::result_t res_q, res_d, res_n;

	logic [CW-1:0] count;
	logic [CW-1:0] half;
	logic [CW-1:0] lo_n, len_n;
	logic          taken;

	always_comb begin
		if ({19'b0, entry_count} > 32'(TABLE_DEPTH)) begin
			count = CW'(TABLE_DEPTH);
		end else begin
			count = CW'(entry_count);
		end
	end

	always_comb begin
		half  = len_q >> 1;
		taken = (rd_start <= ip_q);
		if (taken) begin
			lo_n  = lo_q + half + CW'(1);
			len_n = len_q - half - CW'(1);
			res_n.found         = 1'b1;
			res_n.match_index   = iprtl_pkg::IDX_W'(probe_q);
			res_n.match_payload = rd_payload;
		end else begin
			lo_n  = lo_q;
			len_n = half;
			res_n = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iprtl_pkg::ST_IDLE;
			lo_q    <= '0;
			len_q   <= '0;
			probe_q <= '0;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			lo_q    <= lo_d;
			len_q   <= len_d;
			probe_q <= probe_d;
			res_q   <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ip_q <= ip_address;
		end
	end

	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		len_d    = len_q;
		probe_d  = probe_q;
		res_d    = res_q;
		rd_addr  = probe_q;
		res_load = 1'b0;
		res      = res_q;
		idle     = 1'b0;
		case (state_q)
			iprtl_pkg::ST_IDLE: begin
				idle    = 1'b1;
				rd_addr = AW'(count >> 1);
				if (start) begin
					lo_d    = '0;
					len_d   = count;
					probe_d = AW'(count >> 1);
					res_d   = '0;
					state_d = (count == '0) ? iprtl_pkg::ST_FINISH : iprtl_pkg::ST_SEARCH;
				end
			end
			iprtl_pkg::ST_SEARCH: begin
				res = res_n;
				if (len_n == '0) begin
					res_d = res_n;
					if (out_free) begin
						res_load = 1'b1;
						state_d  = iprtl_pkg::ST_IDLE;
					end else begin
						state_d = iprtl_pkg::ST_FINISH;
					end
				end else begin
					lo_d    = lo_n;
					len_d   = len_n;
					res_d   = res_n;
					probe_d = AW'(lo_n + (len_n >> 1));
					rd_addr = AW'(lo_n + (len_n >> 1));
				end
			end
			iprtl_pkg::ST_FINISH: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = iprtl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iprtl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/ip_range_table_lookup_core.sv
// top level of the ip range table lookup core: stream ports, count register, result register
// depends on iprtl_pkg, iprtl_mem and iprtl_search
//
// usage:
// the s channel carries write and lookup items, selected by s_tuser (0 write, 1 lookup).
// a write transfer stores one table entry in the transfer cycle and is ready again next cycle;
// a write to a slot at or beyond TABLE_DEPTH is dropped. the table must be loaded in
// ascending order of range start and only written entries may be searched.
// cfg carries entry_count, the number of valid entries; write it only while the core is idle.
// values above TABLE_DEPTH are clipped to TABLE_DEPTH.
// a lookup makes one memory probe per cycle, at most floor(log2(entry_count)) + 1 probes;
// the sequencer waits on the registered read of the table memory for every probe.
// the result lands in the m register at the end of the last probe, or from the finish state
// once the m register frees up, and gives one result transfer per lookup; writes give none.
// when m_tready is low the core still takes the next item; a finished lookup then holds
// in the sequencer until the m register frees up.
// reset clears the entry count to zero and empties the pipeline; table contents are kept
// undefined until written.
module ip_range_table_lookup_core #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// entry_index[11:0], range_start[43:12], entry_payload[75:44], ip_address[107:76]
	input  logic [iprtl_pkg::S_DATA_W-1:0] s_tdata,
	// opcode[0]
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// match_index[11:0], match_payload[43:12]
	output logic [iprtl_pkg::M_DATA_W-1:0] m_tdata,
	// found[0]
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [iprtl_pkg::CNT_W-1:0]    cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [iprtl_pkg::CNT_W-1:0] entry_count_q;
	logic                        m_valid_q;
	iprtl_pkg::result_t          m_res_q;

	iprtl_pkg::opcode_t          opcode;
	logic [iprtl_pkg::IDX_W-1:0] entry_index;
	logic [iprtl_pkg::IP_W-1:0]  range_start;
	logic [iprtl_pkg::PAY_W-1:0] entry_payload;
	logic [iprtl_pkg::IP_W-1:0]  ip_address;

	logic                        s_xfer;
	logic                        wr_en;
	logic                        lookup_start;
	logic                        idle;
	logic                        out_free;
	logic                        res_load;
	iprtl_pkg::result_t          res;
	logic [AW-1:0]               rd_addr;
	logic [iprtl_pkg::IP_W-1:0]  rd_start;
	logic [iprtl_pkg::PAY_W-1:0] rd_payload;

	assign opcode        = iprtl_pkg::opcode_t'(s_tuser);
	assign entry_index   = s_tdata[11:0];
	assign range_start   = s_tdata[43:12];
	assign entry_payload = s_tdata[75:44];
	assign ip_address    = s_tdata[107:76];

	assign s_tready     = idle;
	assign s_xfer       = s_tvalid && s_tready;
	assign wr_en        = s_xfer && (opcode == iprtl_pkg::OP_WRITE)
	                      && ({20'b0, entry_index} < 32'(TABLE_DEPTH));
	assign lookup_start = s_xfer && (opcode == iprtl_pkg::OP_LOOKUP);
	assign out_free     = !m_valid_q || m_tready;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.found;
	assign m_tdata  = {4'b0, m_res_q.match_payload, m_res_q.match_index};

	iprtl_mem #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (AW'(entry_index)),
		.wr_start  (range_start),
		.wr_payload(entry_payload),
		.rd_addr   (rd_addr),
		.rd_start  (rd_start),
		.rd_payload(rd_payload)
	);

	iprtl_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (lookup_start),
		.entry_count(entry_count_q),
		.ip_address (ip_address),
		.idle       (idle),
		.rd_addr    (rd_addr),
		.rd_start   (rd_start),
		.rd_payload (rd_payload),
		.out_free   (out_free),
		.res_load   (res_load),
		.res        (res)
	);

endmodule

### bench/ip_range_table_lookup_core_test.sv
// self-checking bench for ip_range_table_lookup_core: directed rows, then random table loads and lookups
// predicts untyped lookups with its own bisection over mirrored tables; depends on iprtl_pkg and the rtl
module ip_range_table_lookup_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDX_W    = iprtl_pkg::IDX_W;
	localparam int unsigned IP_W     = iprtl_pkg::IP_W;
	localparam int unsigned PAY_W    = iprtl_pkg::PAY_W;
	localparam int unsigned CNT_W    = iprtl_pkg::CNT_W;
	localparam int unsigned S_DATA_W = iprtl_pkg::S_DATA_W;
	localparam int unsigned M_DATA_W = iprtl_pkg::M_DATA_W;

	localparam int unsigned TABLE_DEPTH    = 4096;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES   = 32;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned RANDOM_ITEMS   = 1400;
	localparam int unsigned REPORT_LIMIT   = 10;

	typedef enum {ROW_ITEM, ROW_COUNT} row_kind_t;
	typedef enum {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

	typedef struct {
		row_kind_t           kind;
		iprtl_pkg::opcode_t  op;
		logic [IDX_W-1:0]    idx;
		logic [IP_W-1:0]     start;
		logic [PAY_W-1:0]    payload;
		logic [IP_W-1:0]     addr;
		logic [CNT_W-1:0]    count;
		bit                  typed;
		iprtl_pkg::result_t  want;
	} stim_row_t;

	localparam iprtl_pkg::result_t NO_MATCH = '0;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic                s_tuser   = 1'b0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data  = '0;

	logic [IP_W-1:0]    start_mirror [TABLE_DEPTH];
	logic [PAY_W-1:0]   payload_mirror [TABLE_DEPTH];
	bit                 written_mirror [TABLE_DEPTH];
	logic [CNT_W-1:0]   count_mirror = '0;
	iprtl_pkg::result_t pending_matches [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req      = 1'b0;
	int unsigned hold_left     = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned mismatches    = 0;

	stim_row_t directed_rows [22] = '{
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0, 13'd0, 1'b1,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 13'd0, 1'b1,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd0, 32'h0000_0010, 32'hFFFF_FFFF, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd1, 32'h0A00_0000, 32'h1234_5678, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd2, 32'h8000_0000, 32'h0, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd3, 32'hFFFF_FFFF, 32'hCAFE_F00D, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd4095, 32'hFFFF_FFFF, 32'h0, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_COUNT, iprtl_pkg::OP_WRITE, 12'd0, 32'h0, 32'h0, 32'h0, 13'd4, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0, 13'd0, 1'b1,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0000_000F, 13'd0, 1'b1,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0000_0010, 13'd0, 1'b1,
			'{1'b1, 12'd0, 32'hFFFF_FFFF}},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 13'd0, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'hFFFF_FFFE, 13'd0, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 13'd0, 1'b1,
			'{1'b1, 12'd3, 32'hCAFE_F00D}},
		'{ROW_COUNT, iprtl_pkg::OP_WRITE, 12'd0, 32'h0, 32'h0, 32'h0, 13'd1, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 13'd0, 1'b1,
			'{1'b1, 12'd0, 32'hFFFF_FFFF}},
		'{ROW_ITEM, iprtl_pkg::OP_WRITE, 12'd1, 32'h0000_0005, 32'hA5A5_A5A5, 32'h0, 13'd0,
			1'b0, NO_MATCH},
		'{ROW_COUNT, iprtl_pkg::OP_WRITE, 12'd0, 32'h0, 32'h0, 32'h0, 13'd2, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0000_0008, 13'd0, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0000_0004, 13'd0, 1'b0,
			NO_MATCH},
		'{ROW_COUNT, iprtl_pkg::OP_WRITE, 12'd0, 32'h0, 32'h0, 32'h0, 13'd0, 1'b0,
			NO_MATCH},
		'{ROW_ITEM, iprtl_pkg::OP_LOOKUP, 12'd0, 32'h0, 32'h0, 32'h0000_0010, 13'd0, 1'b1,
			NO_MATCH}
	};

	ip_range_table_lookup_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1ns clk = ~clk;

	function automatic int unsigned active_span();
		return (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : 32'(count_mirror);
	endfunction

	function automatic iprtl_pkg::result_t search_ranges(logic [IP_W-1:0] addr);
		int unsigned        lo;
		int unsigned        len;
		int unsigned        half;
		iprtl_pkg::result_t match;
		lo = 0;
		len = active_span();
		while (len > 0) begin
			half = len / 2;
			if (start_mirror[lo + half] <= addr) begin
				lo = lo + half + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		match = NO_MATCH;
		if (lo != 0) begin
			match.found = 1'b1;
			match.match_index = IDX_W'(lo - 1);
			match.match_payload = payload_mirror[lo - 1];
		end
		return match;
	endfunction

	// first entry on the search path that was never written, or -1
	function automatic int first_unwritten_probe(logic [IP_W-1:0] addr);
		int unsigned lo;
		int unsigned len;
		int unsigned half;
		lo = 0;
		len = active_span();
		while (len > 0) begin
			half = len / 2;
			if (!written_mirror[lo + half])
				return int'(lo + half);
			if (start_mirror[lo + half] <= addr) begin
				lo = lo + half + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		return -1;
	endfunction

	function automatic void set_idle_mode(idle_mode_t mode);
		case (mode)
			IDLE_SEND_LIGHT: begin
				send_idle_pct = 20;
				recv_idle_pct = 70;
			end
			IDLE_SEND_HEAVY: begin
				send_idle_pct = 70;
				recv_idle_pct = 20;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	task automatic send_item(iprtl_pkg::opcode_t op, logic [IDX_W-1:0] idx,
			logic [IP_W-1:0] start, logic [PAY_W-1:0] payload, logic [IP_W-1:0] addr,
			bit typed, iprtl_pkg::result_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(S_DATA_W - 108){1'b0}}, addr, payload, start, idx};
		do @(posedge clk); while (!s_tready);
		if (op == iprtl_pkg::OP_WRITE) begin
			start_mirror[idx] = start;
			payload_mirror[idx] = payload;
			written_mirror[idx] = 1'b1;
		end else begin
			pending_matches.push_back(typed ? want : search_ranges(addr));
		end
	endtask

	task automatic set_entry_count(logic [CNT_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		count_mirror = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_table(int unsigned entries, bit ascending);
		longint unsigned step_max;
		longint unsigned next_start;
		step_max = 64'hFFFF_FFFF / entries;
		next_start = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 32'(step_max));
		for (int unsigned i = 0; i < entries; i++) begin
			send_item(iprtl_pkg::OP_WRITE, IDX_W'(i), ascending ? IP_W'(next_start) : $urandom,
				$urandom, $urandom, 1'b0, NO_MATCH);
			next_start += $urandom_range(0, 32'(step_max - 1));
		end
	endtask

	task automatic run_lookups(int unsigned items);
		int unsigned     pick;
		int unsigned     span;
		int unsigned     slot;
		int              gap;
		logic [IP_W-1:0] addr;
		for (int unsigned i = 0; i < items; i++) begin
			span = active_span();
			pick = $urandom_range(99);
			if ($urandom_range(99) < 12) begin
				send_item(iprtl_pkg::OP_WRITE, IDX_W'($urandom), $urandom, $urandom, $urandom,
					1'b0, NO_MATCH);
			end else begin
				if (span != 0 && pick < 55) begin
					slot = $urandom_range(span - 1);
					if (written_mirror[slot])
						addr = start_mirror[slot] + IP_W'($urandom_range(2)) - IP_W'(1);
					else
						addr = $urandom;
				end else if (pick < 65)
					addr = ($urandom_range(1) != 0) ? '1 : '0;
				else
					addr = $urandom;
				// a lookup that would probe an unwritten entry becomes a write to it
				gap = first_unwritten_probe(addr);
				if (gap >= 0)
					send_item(iprtl_pkg::OP_WRITE, IDX_W'(gap), $urandom, $urandom, $urandom,
						1'b0, NO_MATCH);
				else
					send_item(iprtl_pkg::OP_LOOKUP, IDX_W'($urandom), $urandom, $urandom, addr,
						1'b0, NO_MATCH);
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		iprtl_pkg::result_t got;
		iprtl_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.found = m_tuser;
			got.match_index = m_tdata[11:0];
			got.match_payload = m_tdata[43:12];
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result transfer: found %0b index %0d payload %h",
						got.found, got.match_index, got.match_payload);
			end else begin
				want = pending_matches.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("lookup mismatch: expected %0b/%0d/%h, got %0b/%0d/%h",
							want.found, want.match_index, want.match_payload,
							got.found, got.match_index, got.match_payload);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned items_done;
		int unsigned entries;
		int unsigned pick;
		int unsigned lookups;
		int unsigned phase;
		logic [CNT_W-1:0] count;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_idle_mode(IDLE_NONE);
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_COUNT)
				set_entry_count(directed_rows[i].count);
			else
				send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].start,
					directed_rows[i].payload, directed_rows[i].addr, directed_rows[i].typed,
					directed_rows[i].want);
		end

		// small ascending table, then a long receiver stall
		set_idle_mode(IDLE_SEND_LIGHT);
		load_table(64, 1'b1);
		set_entry_count(CNT_W'(64));
		hold_req = 1'b1;
		run_lookups(150);

		items_done = 0;
		phase = 0;
		while (items_done < RANDOM_ITEMS) begin
			if (items_done < RANDOM_ITEMS / 3)
				set_idle_mode(IDLE_SEND_LIGHT);
			else if (items_done < 2 * RANDOM_ITEMS / 3)
				set_idle_mode(IDLE_SEND_HEAVY);
			else
				set_idle_mode(IDLE_NONE);
			pick = $urandom_range(99);
			if (pick < 85)
				entries = $urandom_range(1, 32);
			else if (pick < 95)
				entries = $urandom_range(33, 512);
			else
				entries = $urandom_range(513, 1024);
			load_table(entries, $urandom_range(9) != 0);
			items_done += entries;
			pick = $urandom_range(99);
			if (phase == 0)
				count = '1;
			else if (pick < 70)
				count = CNT_W'(entries);
			else if (pick < 75)
				count = '0;
			else if (pick < 80)
				count = CNT_W'(TABLE_DEPTH);
			else if (pick < 85)
				count = '1;
			else if (pick < 90)
				count = CNT_W'($urandom_range(TABLE_DEPTH + 1, 8191));
			else
				count = CNT_W'($urandom_range(0, entries));
			set_entry_count(count);
			lookups = $urandom_range(20, 80);
			run_lookups(lookups);
			items_done += lookups;
			phase++;
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += pending_matches.size();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
hdl/iprtl_pkg.sv
hdl/iprtl_mem.sv
hdl/iprtl_search.sv
hdl/ip_range_table_lookup_core.sv
bench/ip_range_table_lookup_core_test.sv
